### hw/rtl/temperature_setpoint_frame_encoder_core_macros.svh
`ifndef TEMPERATURE_SETPOINT_FRAME_ENCODER_CORE_MACROS_SVH
`define TEMPERATURE_SETPOINT_FRAME_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define TSFE_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define TSFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/tsfe_pkg.sv
`default_nettype none

package tsfe_pkg;

	localparam int TEMP_W = 17;
	localparam int FRAME_LEN = 11;
	localparam int IDX_W = $clog2(FRAME_LEN);

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [7:0] byte_t;
	typedef logic [IDX_W-1:0] idx_t;

	// 50 and 95 degrees F in 1/256 degree units
	localparam temp_t DEF_MIN_TEMP = 17'sd12800;
	localparam temp_t DEF_MAX_TEMP = 17'sd24320;

	localparam logic REG_MIN_TEMP = 1'b0;
	localparam logic REG_MAX_TEMP = 1'b1;

	localparam byte_t BYTE_SYNC = 8'h5a;
	localparam byte_t BYTE_ADDR = 8'h01;
	localparam byte_t BYTE_LEN  = 8'h09;
	localparam byte_t BYTE_ZERO = 8'h00;
	localparam byte_t BYTE_CMD  = 8'h05;
	localparam byte_t BYTE_SUB  = 8'h2b;
	localparam byte_t BYTE_ONE  = 8'h01;
	localparam byte_t BYTE_TAIL = 8'h32;

	localparam idx_t POS_SYNC  = 4'd0;
	localparam idx_t POS_ADDR  = 4'd1;
	localparam idx_t POS_LEN   = 4'd2;
	localparam idx_t POS_ZERO  = 4'd3;
	localparam idx_t POS_CMD   = 4'd4;
	localparam idx_t POS_SUB   = 4'd5;
	localparam idx_t POS_ONE   = 4'd6;
	localparam idx_t POS_WHOLE = 4'd7;
	localparam idx_t POS_FINE  = 4'd8;
	localparam idx_t POS_TAIL  = 4'd9;
	localparam idx_t POS_CSUM  = 4'd10;

	// XOR of the fixed bytes covered by the checksum
	localparam byte_t HDR_XOR = BYTE_ADDR ^ BYTE_LEN ^ BYTE_ZERO ^ BYTE_CMD ^ BYTE_SUB
		^ BYTE_ONE ^ BYTE_TAIL;

	localparam byte_t FINE_CARRY_LIMIT = 8'd99;

	typedef struct packed {
		byte_t whole;
		byte_t fine;
		byte_t csum;
	} frame_info_t;

	function automatic byte_t frame_const(input idx_t pos);
		byte_t b;
		unique case (pos)
			POS_SYNC: b = BYTE_SYNC;
			POS_ADDR: b = BYTE_ADDR;
			POS_LEN:  b = BYTE_LEN;
			POS_ZERO: b = BYTE_ZERO;
			POS_CMD:  b = BYTE_CMD;
			POS_SUB:  b = BYTE_SUB;
			POS_ONE:  b = BYTE_ONE;
			POS_TAIL: b = BYTE_TAIL;
			default:  b = BYTE_ZERO;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/tsfe_calc.sv
`default_nettype none
`include "temperature_setpoint_frame_encoder_core_macros.svh"

module tsfe_calc (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire tsfe_pkg::temp_t      target_temp,
	input  wire tsfe_pkg::temp_t      min_temp,
	input  wire tsfe_pkg::temp_t      max_temp,
	output logic                      dn_valid,
	input  wire logic                 dn_ready,
	output tsfe_pkg::frame_info_t     dn_info
);

	// floor(m / 896) for m below 2^17: shift by 7, then divide by 7 via reciprocal
	function automatic tsfe_pkg::byte_t div896(input logic [16:0] m);
		logic [20:0] p;
		p = 21'(m[16:7]) * 21'd1171;
		return p[20:13];
	endfunction

	logic v1_q, v2_q, v3_q;
	logic adv1, adv2, adv3;

	tsfe_pkg::temp_t t_s1;
	logic [8:0]  q_s2;
	logic [19:0] ap_s2;
	tsfe_pkg::byte_t w_s3, fine1_s3, fine2_s3;

	tsfe_pkg::temp_t lo, hi, tc;
	logic signed [17:0] diff;
	logic signed [20:0] a;
	logic [12:0] u13;
	logic [24:0] prod;
	logic [19:0] ap_d;

	logic [12:0] q9;
	logic [20:0] dd;
	logic [16:0] n;
	tsfe_pkg::byte_t fine1_d, fine2_d;

	logic carry;
	tsfe_pkg::byte_t whole, fine;

	assign adv3 = !v3_q || dn_ready;
	assign adv2 = !v2_q || adv3;
	assign adv1 = !v1_q || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= in_valid;
			if (adv2) v2_q <= v1_q;
			if (adv3) v3_q <= v2_q;
		end
	end

	// Stage 1: clamp, scale to Celsius steps, divide by 2304
	always_comb begin
		if (min_temp < max_temp) begin
			lo = min_temp;
			hi = max_temp;
		end else begin
			lo = tsfe_pkg::DEF_MIN_TEMP;
			hi = tsfe_pkg::DEF_MAX_TEMP;
		end
		if (t_s1 < lo)
			tc = lo;
		else if (t_s1 > hi)
			tc = hi;
		else
			tc = t_s1;
		diff = 18'(tc) - 18'sd8192;
		a    = 21'(diff) * 21'sd5;
		// bias by 160*9 so the divide by 9 works on a non-negative value
		u13  = {a[19], a[19:8]} + 13'd1440;
		prod = 25'(u13[11:0]) * 25'd7282;
		ap_d = 20'(a + 21'sd368640);
	end

	always_ff @(posedge clk) begin
		if (adv1) t_s1 <= target_temp;
		if (adv2) begin
			q_s2  <= prod[24:16];
			ap_s2 <= ap_d;
		end
		if (adv3) begin
			w_s3     <= q_s2[7:0] - 8'd160;
			fine1_s3 <= fine1_d;
			fine2_s3 <= fine2_d;
		end
	end

	// Stage 2: remainder in 1/1280 degree F, then the fine step for both candidates
	always_comb begin
		q9 = 13'({q_s2, 3'b000}) + 13'(q_s2);
		dd = {1'b0, ap_s2} - {q9, 8'b0};
		n  = 17'd5376 + 17'(dd[11:0]) * 17'd37;
		fine1_d = div896(n + 17'd448);
		// next whole degree: negative results clamp to zero
		if (n >= 17'd84800)
			fine2_d = div896(n - 17'd84800);
		else
			fine2_d = 8'd0;
	end

	// Stage 3 output: carry into the whole degree when fine overflows
	always_comb begin
		carry = fine1_s3 > tsfe_pkg::FINE_CARRY_LIMIT;
		whole = w_s3 + 8'(carry);
		fine  = carry ? fine2_s3 : fine1_s3;
		dn_info.whole = whole;
		dn_info.fine  = fine;
		dn_info.csum  = tsfe_pkg::HDR_XOR ^ whole ^ fine;
	end

	assign dn_valid = v3_q;

	`TSFE_ASSERT_IMPLY(a_fine_range, v3_q, dn_info.fine <= tsfe_pkg::FINE_CARRY_LIMIT, "fine step out of range")
	`TSFE_ASSERT_NEXT(a_s3_hold, v3_q && !dn_ready, v3_q && $stable(dn_info), "stage 3 lost while stalled")
	`TSFE_ASSERT_NEXT(a_s1_fill, in_valid && in_ready, v1_q, "accepted setpoint not in stage 1")

endmodule

`default_nettype wire

### hw/rtl/tsfe_ser.sv
`default_nettype none
`include "temperature_setpoint_frame_encoder_core_macros.svh"

module tsfe_ser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 ld_valid,
	output logic                      ld_ready,
	input  wire tsfe_pkg::frame_info_t ld_info,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output tsfe_pkg::byte_t           frame_byte,
	output logic                      last_byte
);

	localparam tsfe_pkg::idx_t LAST_IDX = tsfe_pkg::idx_t'(tsfe_pkg::FRAME_LEN - 1);

	logic busy_q;
	tsfe_pkg::idx_t idx_q;
	tsfe_pkg::frame_info_t info_q;
	logic xfer;

	assign xfer      = busy_q && out_ready;
	assign last_byte = idx_q == LAST_IDX;
	assign ld_ready  = !busy_q || (out_ready && last_byte);
	assign out_valid = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (ld_valid && ld_ready) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (xfer) begin
			// drop out after the checksum transfer, else advance
			if (last_byte)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_valid && ld_ready) info_q <= ld_info;
	end

	always_comb begin
		case (idx_q)
			tsfe_pkg::POS_WHOLE: frame_byte = info_q.whole;
			tsfe_pkg::POS_FINE:  frame_byte = info_q.fine;
			tsfe_pkg::POS_CSUM:  frame_byte = info_q.csum;
			default:             frame_byte = tsfe_pkg::frame_const(idx_q);
		endcase
	end

	`TSFE_ASSERT_NEXT(a_mid_frame, xfer && !last_byte, busy_q, "frame cut short")
	`TSFE_ASSERT_IMPLY(a_idx_range, busy_q, idx_q <= LAST_IDX, "byte index past frame end")
	`TSFE_ASSERT_NEXT(a_frame_end, xfer && last_byte && !ld_valid, !busy_q, "extra byte after frame")

endmodule

`default_nettype wire

### hw/rtl/temperature_setpoint_frame_encoder_core.sv
// A setpoint passes calc stages 1-3 and the serialiser register before its
// first frame byte is valid, then one byte per cycle for 11 bytes while
// out_ready stays high. The serialiser takes the next frame only as the
// last byte goes out; up to three further setpoints are held in the arithmetic pipeline meanwhile.
// Reset (arst_n low): pipeline and serialiser empty, limits back to 50/95 F.
`default_nettype none

module temperature_setpoint_frame_encoder_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire tsfe_pkg::temp_t  target_temp,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output tsfe_pkg::byte_t       frame_byte,
	output logic                  last_byte,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_index,
	input  wire tsfe_pkg::temp_t  cfg_data
);

	tsfe_pkg::temp_t min_temp_q, max_temp_q;
	logic dn_valid, dn_ready;
	tsfe_pkg::frame_info_t dn_info;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_temp_q <= tsfe_pkg::DEF_MIN_TEMP;
			max_temp_q <= tsfe_pkg::DEF_MAX_TEMP;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tsfe_pkg::REG_MIN_TEMP: min_temp_q <= cfg_data;
				tsfe_pkg::REG_MAX_TEMP: max_temp_q <= cfg_data;
			endcase
		end
	end

	tsfe_calc u_calc (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.target_temp (target_temp),
		.min_temp    (min_temp_q),
		.max_temp    (max_temp_q),
		.dn_valid    (dn_valid),
		.dn_ready    (dn_ready),
		.dn_info     (dn_info)
	);

	tsfe_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld_valid   (dn_valid),
		.ld_ready   (dn_ready),
		.ld_info    (dn_info),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

`default_nettype wire
